>>> design/bitmap_slot_allocator_top_macros.svh
// Assertion macros for the slot allocator checker.
// Used by bsa_checker only; relies on clk and arst_n in the including scope.
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot allocator check failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot allocator check failed");

`endif

>>> design/bsa_pkg.sv
// Shared types, codes and the bitmap search function for the slot allocator.
// No dependencies; imported by every design file.
package bsa_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int MAX_SLOTS = 256;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int ADDR_W    = 64;
	localparam int DIM_W     = 16;
	localparam int IDX_W     = 8;
	localparam int CNT_W     = 9;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;
	localparam logic [CNT_W-1:0] LIMIT_RST = 9'd256;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} desc_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} find_t;

	// lowest set bit of one bitmap word
	function automatic find_t find_first(input logic [WORD_W-1:0] v);
		find_t r;
		r.hit = |v;
		r.pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.pos = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> design/bsa_store.sv
// Descriptor store: one write port, one registered read port.
// Depends on bsa_pkg for the descriptor type.
module bsa_store #(
	parameter int DEPTH = bsa_pkg::SLOTS_DEF,
	parameter int AW    = 8
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  bsa_pkg::desc_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output bsa_pkg::desc_t rd_data
);
	import bsa_pkg::*;

	desc_t mem [DEPTH];
	desc_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/bitmap_slot_allocator_top.sv
// Slot table allocator: a used-slot bitmap in flip-flops, cleared by reset, and a descriptor
// store in a memory that needs no clearing pass. Depends on bsa_pkg and bsa_store. One
// request is handled at a time and in_ready is high only while the sequencer is idle. An
// allocate searches the bitmap one 64-bit word at a time with the shared priority encoder,
// stopping at the first word with a free slot. A free or read waits on the registered read
// port of the descriptor memory. Each result goes into an output register, so it can be
// drawn while the block takes the next request; the block waits only when that register is
// still full and not being drawn at the time a new result is ready.
module bitmap_slot_allocator_top #(
	parameter int SLOTS = bsa_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsa_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bsa_pkg::OP_W-1:0]       opcode,
	input  logic [bsa_pkg::IDX_W-1:0]      slot_index,
	input  logic [bsa_pkg::ADDR_W-1:0]     item_address,
	input  logic [bsa_pkg::DIM_W-1:0]      item_width,
	input  logic [bsa_pkg::DIM_W-1:0]      item_height,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bsa_pkg::ST_W-1:0]       status,
	output logic [bsa_pkg::IDX_W-1:0]      result_index,
	output logic [bsa_pkg::ADDR_W-1:0]     entry_address,
	output logic [bsa_pkg::DIM_W-1:0]      entry_width,
	output logic [bsa_pkg::DIM_W-1:0]      entry_height,
	output logic [bsa_pkg::CNT_W-1:0]      used_total,
	output logic                           table_changed
);
	import bsa_pkg::*;

	localparam int DEPTH     = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
	localparam int MAP_WORDS = (DEPTH + WORD_W - 1) / WORD_W;
	localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [WW-1:0]    LAST_W  = WW'(MAP_WORDS - 1);
	localparam logic [CNT_W-1:0] WORD_C  = CNT_W'(WORD_W);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  slot_limit_q;
	logic [ADDR_W-1:0] fb_address_q;
	logic [DIM_W-1:0]  fb_width_q;
	logic [DIM_W-1:0]  fb_height_q;

	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [WW-1:0]     wsel_q, wsel_d;

	logic [WORD_W-1:0] map_q [MAP_WORDS];
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic              out_valid_q;
	logic [ST_W-1:0]   status_q, status_d;
	logic [IDX_W-1:0]  res_idx_q, res_idx_d;
	desc_t             entry_q, entry_d;
	logic              changed_q, changed_d;

	logic              in_fire, cfg_fire, take, res_fire;
	logic              map_set, map_clr, mem_we;
	logic [CNT_W-1:0]  lim, base, remain;
	logic [WORD_W-1:0] lim_mask, free_vec;
	find_t             ff;
	logic [IDX_W-1:0]  alloc_idx;
	logic [1:0]        idx_word;
	logic [WW-1:0]     idx_wsel;
	logic              in_map, used_bit, in_range, live, addr_match;
	desc_t             fb, item, rd_data, view;

	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign take     = !out_valid_q || out_ready;

	assign lim  = (slot_limit_q > DEPTH_C) ? DEPTH_C : slot_limit_q;
	assign fb   = '{address: fb_address_q, width: fb_width_q, height: fb_height_q};
	assign item = '{address: addr_q, width: width_q, height: height_q};

	// bitmap search over the current word, bits at or above the limit count as used
	assign base      = CNT_W'(wsel_q) << BIT_W;
	assign remain    = (lim > base) ? lim - base : '0;
	assign lim_mask  = (remain >= WORD_C) ? '1 : ((WORD_W'(1) << remain[BIT_W-1:0]) - WORD_W'(1));
	assign free_vec  = ~map_q[wsel_q] & lim_mask;
	assign ff        = find_first(free_vec);
	assign alloc_idx = IDX_W'(base) | IDX_W'(ff.pos);

	// lookup of the requested slot
	assign idx_word   = idx_q[IDX_W-1:BIT_W];
	assign idx_wsel   = WW'(idx_word);
	assign in_map     = int'(idx_word) < MAP_WORDS;
	assign used_bit   = in_map ? map_q[idx_wsel][idx_q[BIT_W-1:0]] : 1'b0;
	assign in_range   = {1'b0, idx_q} < lim;
	assign live       = in_range && used_bit;
	assign view       = live ? rd_data : fb;
	assign addr_match = rd_data.address == addr_q;

	bsa_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (alloc_idx[AW-1:0]),
		.wr_data (item),
		.rd_en   (in_fire),
		.rd_addr (slot_index[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wsel_d    = wsel_q;
		res_fire  = 1'b0;
		map_set   = 1'b0;
		map_clr   = 1'b0;
		mem_we    = 1'b0;
		cnt_d     = cnt_q;
		status_d  = ST_REJECT;
		res_idx_d = idx_q;
		entry_d   = view;
		changed_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				wsel_d = '0;
				if (in_fire) begin
					state_d = (opcode == OP_ALLOC) ? S_SCAN : S_DECIDE;
				end
			end
			S_SCAN: begin
				if (ff.hit) begin
					if (take) begin
						res_fire  = 1'b1;
						map_set   = 1'b1;
						mem_we    = 1'b1;
						cnt_d     = cnt_q + 1'b1;
						status_d  = ST_DONE;
						res_idx_d = alloc_idx;
						entry_d   = item;
						changed_d = 1'b1;
						state_d   = S_IDLE;
					end
				end else if (wsel_q == LAST_W) begin
					if (take) begin
						res_fire  = 1'b1;
						status_d  = ST_FULL;
						res_idx_d = '0;
						entry_d   = fb;
						state_d   = S_IDLE;
					end
				end else begin
					wsel_d = wsel_q + 1'b1;
				end
			end
			S_DECIDE: begin
				if (take) begin
					res_fire = 1'b1;
					state_d  = S_IDLE;
					case (op_q)
						OP_FREE: begin
							if (live && addr_match) begin
								map_clr   = 1'b1;
								cnt_d     = cnt_q - 1'b1;
								status_d  = ST_DONE;
								entry_d   = fb;
								changed_d = 1'b1;
							end
						end
						OP_READ: begin
							status_d = in_range ? ST_DONE : ST_REJECT;
						end
						default: begin
							status_d = ST_REJECT;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= '0;
			cnt_q  <= '0;
			for (int w = 0; w < MAP_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else begin
			wsel_q <= wsel_d;
			if (res_fire) begin
				cnt_q <= cnt_d;
			end
			if (map_set) begin
				map_q[wsel_q][ff.pos] <= 1'b1;
			end
			if (map_clr) begin
				map_q[idx_wsel][idx_q[BIT_W-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= opcode;
			idx_q    <= slot_index;
			addr_q   <= item_address;
			width_q  <= item_width;
			height_q <= item_height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= LIMIT_RST;
			fb_address_q <= '0;
			fb_width_q   <= '0;
			fb_height_q  <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_SLOT_LIMIT: slot_limit_q <= cfg_data[CNT_W-1:0];
				REG_FB_ADDRESS: fb_address_q <= cfg_data[ADDR_W-1:0];
				REG_FB_WIDTH:   fb_width_q   <= cfg_data[DIM_W-1:0];
				REG_FB_HEIGHT:  fb_height_q  <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q  <= status_d;
			res_idx_q <= res_idx_d;
			entry_q   <= entry_d;
			changed_q <= changed_d;
		end
	end

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_index  = res_idx_q;
	assign entry_address = entry_q.address;
	assign entry_width   = entry_q.width;
	assign entry_height  = entry_q.height;
	assign used_total    = cnt_q;
	assign table_changed = changed_q;

endmodule

>>> design/bsa_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_top_macros.svh.
`include "bitmap_slot_allocator_top_macros.svh"

module bsa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bsa_pkg::ST_W-1:0]  status,
	input logic [bsa_pkg::IDX_W-1:0] result_index,
	input logic                      table_changed
);
	import bsa_pkg::*;

	// one request at a time
	`BSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a full pool touches nothing and gives slot zero
	`BSA_ASSERT_NOW(a_full_quiet, out_valid && status == ST_FULL, !table_changed && result_index == '0)

	`BSA_ASSERT_NOW(a_reject_quiet, out_valid && status == ST_REJECT, !table_changed)

	// hold a stalled word
	`BSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_index))

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_slot_allocator_top: directed and random slot requests,
// each response checked word by word against a shadow slot table kept in a small class.
// Depends on bsa_pkg and the design sources; reads no files.
module testbench;
	import bsa_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int PHASES         = 10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] address;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} request_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] address;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [CNT_W-1:0]  used;
		logic              changed;
	} response_t;

	class slot_table_shadow;
		bit [WORD_W-1:0] used_map [MAX_SLOTS/WORD_W];
		bit [ADDR_W-1:0] slot_address [MAX_SLOTS];
		bit [DIM_W-1:0]  slot_width [MAX_SLOTS];
		bit [DIM_W-1:0]  slot_height [MAX_SLOTS];
		bit [CNT_W-1:0]  used_count;
		bit [CNT_W-1:0]  slot_limit;
		desc_t           fallback;
		response_t       due_responses [$];
		int              mismatches;

		function new();
			slot_limit = LIMIT_RST;
			fallback   = '0;
			used_count = '0;
			mismatches = 0;
		endfunction

		function int live_limit();
			int lim;
			lim = slot_limit;
			if (lim > SLOTS_DEF) lim = SLOTS_DEF;
			if (lim > MAX_SLOTS) lim = MAX_SLOTS;
			return lim;
		endfunction

		function bit in_use(int i);
			return used_map[i / WORD_W][i % WORD_W];
		endfunction

		function desc_t view(int i);
			desc_t d;
			d = fallback;
			if (i < live_limit() && in_use(i)) begin
				d.address = slot_address[i];
				d.width   = slot_width[i];
				d.height  = slot_height[i];
			end
			return d;
		endfunction

		function int pick_live();
			int live [$];
			int lim;
			lim = live_limit();
			for (int i = 0; i < lim; i++) begin
				if (in_use(i)) live.push_back(i);
			end
			if (live.size() == 0) return -1;
			return live[$urandom_range(0, live.size() - 1)];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
			case (index)
				REG_SLOT_LIMIT: slot_limit = data[CNT_W-1:0];
				REG_FB_ADDRESS: fallback.address = data;
				REG_FB_WIDTH:   fallback.width = data[DIM_W-1:0];
				REG_FB_HEIGHT:  fallback.height = data[DIM_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(request_t rq);
			response_t rs;
			desc_t     d;
			int        lim;
			int        slot;
			bit        found;
			lim        = live_limit();
			rs         = '0;
			rs.status  = ST_DONE;
			rs.idx     = rq.idx;
			found      = 0;
			slot       = 0;
			case (rq.op)
				OP_ALLOC: begin
					rs.status = ST_FULL;
					rs.idx    = '0;
					for (int i = 0; i < lim && !found; i++) begin
						if (!in_use(i)) begin
							found = 1;
							slot  = i;
						end
					end
					if (found) begin
						used_map[slot / WORD_W][slot % WORD_W] = 1'b1;
						slot_address[slot] = rq.address;
						slot_width[slot]   = rq.width;
						slot_height[slot]  = rq.height;
						used_count = used_count + 1'b1;
						rs.status  = ST_DONE;
						rs.idx     = IDX_W'(slot);
						rs.changed = 1'b1;
						d = view(slot);
					end else begin
						d = fallback;
					end
				end
				OP_FREE: begin
					if (rq.idx < lim && in_use(rq.idx) && slot_address[rq.idx] == rq.address) begin
						used_map[rq.idx / WORD_W][rq.idx % WORD_W] = 1'b0;
						used_count = used_count - 1'b1;
						rs.changed = 1'b1;
					end else begin
						rs.status = ST_REJECT;
					end
					d = view(rq.idx);
				end
				default: begin
					rs.status = (rq.op == OP_READ && rq.idx < lim) ? ST_DONE : ST_REJECT;
					d = view(rq.idx);
				end
			endcase
			rs.address = d.address;
			rs.width   = d.width;
			rs.height  = d.height;
			rs.used    = used_count;
			due_responses.push_back(rs);
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] slot response: %s", $time, what);
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_response(response_t got);
			response_t want;
			if (due_responses.size() == 0) begin
				report("word with no request outstanding");
				return;
			end
			want = due_responses.pop_front();
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("result_index", 64'(got.idx), 64'(want.idx));
			compare_field("entry_address", got.address, want.address);
			compare_field("entry_width", 64'(got.width), 64'(want.width));
			compare_field("entry_height", 64'(got.height), 64'(want.height));
			compare_field("used_total", 64'(got.used), 64'(want.used));
			compare_field("table_changed", 64'(got.changed), 64'(want.changed));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       opcode = '0;
	logic [IDX_W-1:0]      slot_index = '0;
	logic [ADDR_W-1:0]     item_address = '0;
	logic [DIM_W-1:0]      item_width = '0;
	logic [DIM_W-1:0]      item_height = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ST_W-1:0]       status;
	logic [IDX_W-1:0]      result_index;
	logic [ADDR_W-1:0]     entry_address;
	logic [DIM_W-1:0]      entry_width;
	logic [DIM_W-1:0]      entry_height;
	logic [CNT_W-1:0]      used_total;
	logic                  table_changed;

	slot_table_shadow sb = new();
	bit idle_on = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	int phase_limit [PHASES] = '{256, 1, 0, 511, 64, 65, 7, 256, 128, 300};
	int phase_items [PHASES] = '{400, 120, 60, 200, 200, 150, 120, 350, 200, 150};
	int phase_alloc [PHASES] = '{85, 40, 40, 45, 50, 50, 50, 25, 45, 45};
	int phase_free  [PHASES] = '{8, 30, 30, 30, 30, 30, 30, 55, 30, 30};

	bitmap_slot_allocator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.slot_index    (slot_index),
		.item_address  (item_address),
		.item_width    (item_width),
		.item_height   (item_height),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.result_index  (result_index),
		.entry_address (entry_address),
		.entry_width   (entry_width),
		.entry_height  (entry_height),
		.used_total    (used_total),
		.table_changed (table_changed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic request_t req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
			logic [ADDR_W-1:0] address, logic [DIM_W-1:0] width, logic [DIM_W-1:0] height);
		request_t rq;
		rq.op      = op;
		rq.idx     = idx;
		rq.address = address;
		rq.width   = width;
		rq.height  = height;
		return rq;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_address();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return DIM_W'($urandom());
		endcase
	endfunction

	function automatic request_t random_request(int alloc_pct, int free_pct);
		request_t rq;
		int       roll;
		int       pick;
		rq   = req(OP_ALLOC, IDX_W'($urandom_range(0, 255)), rand_address(), rand_dim(),
			rand_dim());
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) begin
			rq.op = OP_ALLOC;
		end else if (roll < alloc_pct + free_pct) begin
			rq.op = OP_FREE;
			pick  = sb.pick_live();
			if (pick >= 0 && $urandom_range(0, 99) < 80) begin
				rq.idx     = IDX_W'(pick);
				rq.address = sb.slot_address[pick];
				if ($urandom_range(0, 9) == 0) begin
					pick = $urandom_range(0, ADDR_W - 1);
					rq.address[pick] = ~rq.address[pick];
				end
			end
		end else if (roll < 96) begin
			rq.op = OP_READ;
			pick  = sb.pick_live();
			if (pick >= 0 && $urandom_range(0, 1) == 1) rq.idx = IDX_W'(pick);
		end else begin
			rq.op = OP_SPARE;
		end
		return rq;
	endfunction

	task automatic send_item(request_t rq);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= rq.op;
		slot_index   <= rq.idx;
		item_address <= rq.address;
		item_width   <= rq.width;
		item_height  <= rq.height;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(index, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [CNT_W-1:0] limit, logic [ADDR_W-1:0] fb_address,
			logic [DIM_W-1:0] fb_width, logic [DIM_W-1:0] fb_height);
		write_reg(REG_SLOT_LIMIT, CFG_W'(limit));
		write_reg(REG_FB_ADDRESS, fb_address);
		write_reg(REG_FB_WIDTH, CFG_W'(fb_width));
		write_reg(REG_FB_HEIGHT, CFG_W'(fb_height));
		cfg_valid <= 1'b0;
	endtask

	// hold off until every response is in, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_responses.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [ADDR_W-1:0] fb_address;
		logic [DIM_W-1:0]  fb_width;
		logic [DIM_W-1:0]  fb_height;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		configure(LIMIT_RST, 64'h0123_4567_89ab_cdef, 16'h1234, 16'hfedc);
		send_item(req(OP_READ, 8'd0, '0, '0, '0));
		send_item(req(OP_READ, 8'd255, '1, '1, '1));
		send_item(req(OP_FREE, 8'd0, '0, '0, '0));
		send_item(req(OP_SPARE, 8'd255, '0, '0, '0));
		send_item(req(OP_ALLOC, 8'd255, '1, '1, '1));
		send_item(req(OP_ALLOC, 8'd0, '0, '0, '0));
		send_item(req(OP_READ, 8'd0, '0, '0, '0));
		send_item(req(OP_READ, 8'd1, '0, '0, '0));
		send_item(req(OP_FREE, 8'd0, '0, '0, '0));
		send_item(req(OP_FREE, 8'd0, '1, '0, '0));
		send_item(req(OP_READ, 8'd0, '0, '0, '0));
		send_item(req(OP_FREE, 8'd0, '1, '0, '0));
		send_item(req(OP_ALLOC, 8'd7, 64'h5, 16'h8000, 16'h0001));
		send_item(req(OP_FREE, 8'd1, '0, '0, '0));
		send_item(req(OP_ALLOC, 8'd0, 64'h8000_0000_0000_0001, 16'h0001, 16'h8000));
		send_item(req(OP_SPARE, 8'd0, '0, '0, '0));
		send_item(req(OP_READ, 8'd2, '0, '0, '0));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p % 3)
				0: begin
					fb_address = '1;
					fb_width   = '1;
					fb_height  = '1;
				end
				1: begin
					fb_address = '0;
					fb_width   = '0;
					fb_height  = '0;
				end
				default: begin
					fb_address = {$urandom(), $urandom()};
					fb_width   = DIM_W'($urandom());
					fb_height  = DIM_W'($urandom());
				end
			endcase
			configure(CNT_W'(phase_limit[p]), fb_address, fb_width, fb_height);
			idle_on = (p % 4 != 2) && (p != PHASES - 1);
			repeat (phase_items[p]) send_item(random_request(phase_alloc[p], phase_free[p]));
		end
		drain();

		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_response('{status, result_index, entry_address, entry_width, entry_height,
				used_total, table_changed});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule

>>> filelist.f
+incdir+design
design/bsa_pkg.sv
design/bsa_store.sv
design/bitmap_slot_allocator_top.sv
design/bsa_checker.sv
test/testbench.sv
